/* hw/rtl/llsf_pkg.sv */
// ----------------------------------------------------------------------------
// llsf_pkg
// Shared widths, register indexes and types of the longest line segment
// finder.
// ----------------------------------------------------------------------------
package llsf_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int COORD_W   = 10;
    localparam int LEN_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_VERTICAL = 2'd2;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DIM);

    // Write and frame-clear request to the per-column run store.
    typedef struct packed {
        logic               en;
        logic               clear;
        logic [COORD_W-1:0] addr;
        logic [LEN_W-1:0]   data;
    } col_wr_t;

endpackage

/* hw/rtl/llsf_col_store.sv */
// ----------------------------------------------------------------------------
// llsf_col_store
// Per-column open run lengths in a 1024-entry memory with a registered read.
// A fill mark tells which columns were written in the current frame, so the
// store reads as zero after a frame clear without a clearing pass.
// ----------------------------------------------------------------------------
module llsf_col_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [llsf_pkg::COORD_W-1:0] rd_addr,
    input  llsf_pkg::col_wr_t       wr,
    output logic [llsf_pkg::LEN_W-1:0]   rd_data
);
    import llsf_pkg::*;

    logic [LEN_W-1:0]   col_len_mem [MAX_DIM];
    logic [LEN_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_valid_next;
    logic [LEN_W-1:0]   fill_reg;
    logic [LEN_W-1:0]   fill_next;
    logic [LEN_W-1:0]   wr_end;

    // Columns are visited in order from zero, so the written set is a prefix.
    always_comb
    begin
        wr_end = {1'b0, wr.addr} + LEN_W'(1);
        if (wr.en && wr.clear) begin
            fill_next = '0;
        end else if (wr.en && (wr_end > fill_reg)) begin
            fill_next = wr_end;
        end else begin
            fill_next = fill_reg;
        end
        rd_valid_next = ({1'b0, rd_addr} < fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en) begin
            col_len_mem[wr.addr] <= wr.data;
        end
        if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_reg <= wr.data;
        end else begin
            rd_data_reg <= col_len_mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/longest_line_segment_finder.sv */
// ----------------------------------------------------------------------------
// longest_line_segment_finder
// Finds the longest horizontal or vertical run of set pixels in a binary
// image streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid / pixel_ready), one item per
// cycle while pixel_ready is high, row 0 left to right, then row 1, and so on.
// The image size and the search direction are to be set on the cfg port
// between frames; the block does not enforce this. It takes one pixel every
// cycle but for the stall below. Each pixel updates the run trackers and the
// best run; the per-column run store is read ahead from the next column
// address, so it does not slow the stream. The last pixel of a frame loads
// the result register, and the result item appears on result_valid the cycle
// after that pixel is taken. A stalled receiver only holds back the last
// pixel of the next frame; all other pixels keep flowing while a result waits.
// Reset returns the size registers to 1 by 1, selects the horizontal search
// and starts a new frame. The per-column store needs no clearing pass.
// ----------------------------------------------------------------------------
module longest_line_segment_finder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [llsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [llsf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic                           pixel,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           found,
    output logic [llsf_pkg::COORD_W-1:0]   start_row,
    output logic [llsf_pkg::COORD_W-1:0]   start_col,
    output logic [llsf_pkg::COORD_W-1:0]   end_row,
    output logic [llsf_pkg::COORD_W-1:0]   end_col
);
    import llsf_pkg::*;

    function automatic logic [COORD_W-1:0] start_of(input logic [COORD_W-1:0] last,
                                                    input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] span;
        span = {1'b0, last} + LEN_W'(1);
        if (len > span) begin
            return '0;
        end
        return COORD_W'(span - len);
    endfunction

    function automatic logic [LEN_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return LEN_W'(1);
        end
        if (LEN_W'(v) > MAX_LEN) begin
            return MAX_LEN;
        end
        return LEN_W'(v);
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        if (v >= MAX_LEN) begin
            return MAX_LEN;
        end
        return v + LEN_W'(1);
    endfunction

    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    logic               vert_reg;

    logic [COORD_W-1:0] cur_row_reg, cur_row_next;
    logic [COORD_W-1:0] cur_col_reg, cur_col_next;
    logic [LEN_W-1:0]   row_run_reg, row_run_next;

    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic [COORD_W-1:0] best_sr_reg, best_sr_next;
    logic [COORD_W-1:0] best_sc_reg, best_sc_next;
    logic [COORD_W-1:0] best_er_reg, best_er_next;
    logic [COORD_W-1:0] best_ec_reg, best_ec_next;

    logic               res_valid_reg;
    logic               res_found_reg;
    logic [COORD_W-1:0] res_sr_reg, res_sc_reg, res_er_reg, res_ec_reg;

    logic [LEN_W-1:0]   rows_eff, cols_eff;
    logic               last_col, last_row, frame_last;
    logic               accept;
    logic [LEN_W-1:0]   col_run;
    logic [LEN_W-1:0]   row_inc, col_inc;

    logic               cand;
    logic               cand_vert;
    logic [LEN_W-1:0]   cand_len;
    logic [COORD_W-1:0] cand_er, cand_ec, cand_sr, cand_sc;
    logic               take_it;
    logic               best_found;

    col_wr_t            col_wr;

    llsf_col_store u_col_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (cur_col_next),
        .wr      (col_wr),
        .rd_data (col_run)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rows_reg <= CFG_W'(1);
            cols_reg <= CFG_W'(1);
            vert_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_ROWS:      rows_reg <= cfg_wdata;
                REG_IMAGE_COLS:      cols_reg <= cfg_wdata;
                REG_SEARCH_VERTICAL: vert_reg <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        rows_eff   = eff_dim(rows_reg);
        cols_eff   = eff_dim(cols_reg);
        last_col   = ({1'b0, cur_col_reg} + LEN_W'(1)) >= cols_eff;
        last_row   = ({1'b0, cur_row_reg} + LEN_W'(1)) >= rows_eff;
        frame_last = last_col && last_row;

        // Only the pixel that closes a frame needs room in the result register.
        pixel_ready = !res_valid_reg || result_ready || !frame_last;
        accept      = pixel_valid && pixel_ready;

        row_inc = sat_inc(row_run_reg);
        col_inc = sat_inc(col_run);

        // At most one run can end at a pixel, since the mode picks one tracker.
        cand_vert = vert_reg;
        cand      = 1'b0;
        cand_len  = row_inc;
        cand_er   = cur_row_reg;
        cand_ec   = cur_col_reg;
        if (pixel) begin
            if (vert_reg) begin
                cand     = last_row;
                cand_len = col_inc;
            end else begin
                cand     = last_col;
                cand_len = row_inc;
            end
        end else begin
            if (vert_reg) begin
                cand     = (col_run != '0) && (cur_row_reg != '0);
                cand_len = col_run;
                cand_er  = cur_row_reg - COORD_W'(1);
            end else begin
                cand     = (row_run_reg != '0) && (cur_col_reg != '0);
                cand_len = row_run_reg;
                cand_ec  = cur_col_reg - COORD_W'(1);
            end
        end

        if (cand_vert) begin
            cand_sr = start_of(cand_er, cand_len);
            cand_sc = cand_ec;
        end else begin
            cand_sr = cand_er;
            cand_sc = start_of(cand_ec, cand_len);
        end

        // A vertical tie goes to the smaller column.
        take_it = cand && ((cand_len > best_len_reg) ||
                  (cand_vert && (cand_len == best_len_reg) && (cand_ec < best_sc_reg)));

        best_len_next = take_it ? cand_len : best_len_reg;
        best_sr_next  = take_it ? cand_sr  : best_sr_reg;
        best_sc_next  = take_it ? cand_sc  : best_sc_reg;
        best_er_next  = take_it ? cand_er  : best_er_reg;
        best_ec_next  = take_it ? cand_ec  : best_ec_reg;
        best_found    = best_len_next >= LEN_W'(2);

        row_run_next = (pixel && !last_col) ? row_inc : '0;

        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (accept) begin
            if (last_col) begin
                cur_col_next = '0;
                cur_row_next = last_row ? '0 : cur_row_reg + COORD_W'(1);
            end else begin
                cur_col_next = cur_col_reg + COORD_W'(1);
            end
        end

        col_wr.en    = accept;
        col_wr.clear = frame_last;
        col_wr.addr  = cur_col_reg;
        col_wr.data  = pixel ? col_inc : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            row_run_reg  <= '0;
            best_len_reg <= '0;
            best_sr_reg  <= '0;
            best_sc_reg  <= '0;
            best_er_reg  <= '0;
            best_ec_reg  <= '0;
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            if (accept) begin
                if (frame_last) begin
                    row_run_reg  <= '0;
                    best_len_reg <= '0;
                    best_sr_reg  <= '0;
                    best_sc_reg  <= '0;
                    best_er_reg  <= '0;
                    best_ec_reg  <= '0;
                end else begin
                    row_run_reg  <= row_run_next;
                    best_len_reg <= best_len_next;
                    best_sr_reg  <= best_sr_next;
                    best_sc_reg  <= best_sc_next;
                    best_er_reg  <= best_er_next;
                    best_ec_reg  <= best_ec_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (accept && frame_last) begin
            res_valid_reg <= 1'b1;
        end else if (result_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && frame_last) begin
            res_found_reg <= best_found;
            res_sr_reg    <= best_found ? best_sr_next : '0;
            res_sc_reg    <= best_found ? best_sc_next : '0;
            res_er_reg    <= best_found ? best_er_next : '0;
            res_ec_reg    <= best_found ? best_ec_next : '0;
        end
    end

    assign result_valid = res_valid_reg;
    assign found        = res_found_reg;
    assign start_row    = res_sr_reg;
    assign start_col    = res_sc_reg;
    assign end_row      = res_er_reg;
    assign end_col      = res_ec_reg;

endmodule

/* hw/rtl/llsf_checker.sv */
// ----------------------------------------------------------------------------
// llsf_checker
// Port-level checks of the longest line segment finder, bound to the top
// level.
// ----------------------------------------------------------------------------
module llsf_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    input  logic                           pixel_ready,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  logic                           found,
    input  logic [llsf_pkg::COORD_W-1:0]   start_row,
    input  logic [llsf_pkg::COORD_W-1:0]   start_col,
    input  logic [llsf_pkg::COORD_W-1:0]   end_row,
    input  logic [llsf_pkg::COORD_W-1:0]   end_col
);
    import llsf_pkg::*;

    // A stalled result item holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(found) && $stable(start_row) && $stable(start_col)
            && $stable(end_row) && $stable(end_col))
        else $error("result item changed while stalled");

    // A new result item follows the pixel that closed a frame.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_valid && pixel_ready))
        else $error("result item without a closing pixel");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |->
            start_row == '0 && start_col == '0 && end_row == '0 && end_col == '0)
        else $error("coordinates not zero when nothing was found");

    // A found segment is straight and runs forward.
    a_straight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> (start_row == end_row) || (start_col == end_col))
        else $error("segment is neither horizontal nor vertical");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |->
            (start_row <= end_row) && (start_col <= end_col)
            && !((start_row == end_row) && (start_col == end_col)))
        else $error("segment ends before it starts or is shorter than two");

endmodule

bind longest_line_segment_finder llsf_checker u_llsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .found        (found),
    .start_row    (start_row),
    .start_col    (start_col),
    .end_row      (end_row),
    .end_col      (end_col)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the longest line segment finder. A table of
// directed frames covers the size extremes, both search directions, ties,
// lone pixels and a size and direction change in the middle of a frame.
// Random frames follow with random sizes, fill densities, partial frames,
// random idle cycles on both channels and a long receiver stall. Every
// result is checked field by field against the table or a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
    import llsf_pkg::*;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
    } seg_result_t;

    typedef enum logic [1:0] {FILL_ZERO, FILL_ONE, FILL_MASK} fill_t;

    // One directed frame. The mask gives pixel n of the frame as bit n mod 64.
    typedef struct packed {
        bit                 set_cfg;
        logic [CFG_W-1:0]   rows;
        logic [CFG_W-1:0]   cols;
        logic               vert;
        fill_t              fill;
        logic [63:0]        mask;
        logic [4:0]         mid_at;
        bit                 typed;
        seg_result_t        want;
    } frame_case_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam seg_result_t NO_SEGMENT = '0;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 400;
    localparam int IDLE_PERCENT  = 21;

    // Size and direction written in the middle of the frame that asks for it.
    localparam logic [CFG_W-1:0] MID_ROWS = 11'd3;
    localparam logic [CFG_W-1:0] MID_COLS = 11'd2;
    localparam logic             MID_VERT = 1'b1;

    localparam int NUM_CASES = 16;
    localparam frame_case_t FRAME_CASES [NUM_CASES] = '{
        '{1'b0, 11'd1, 11'd1, 1'b0, FILL_ONE, 64'h0, 5'd0, 1'b1, NO_SEGMENT},
        '{1'b1, 11'd1, 11'd2, 1'b0, FILL_ONE, 64'h0, 5'd0, 1'b1,
          '{1'b1, 10'd0, 10'd0, 10'd0, 10'd1}},
        '{1'b1, 11'd0, 11'd0, 1'b1, FILL_ONE, 64'h0, 5'd0, 1'b1, NO_SEGMENT},
        '{1'b1, 11'd1, 11'd2047, 1'b0, FILL_ONE, 64'h0, 5'd0, 1'b1,
          '{1'b1, 10'd0, 10'd0, 10'd0, 10'd1023}},
        '{1'b1, 11'd2047, 11'd1, 1'b1, FILL_ONE, 64'h0, 5'd0, 1'b1,
          '{1'b1, 10'd0, 10'd0, 10'd1023, 10'd0}},
        '{1'b1, 11'd2, 11'd0, 1'b0, FILL_ZERO, 64'h0, 5'd0, 1'b1, NO_SEGMENT},
        '{1'b1, 11'd4, 11'd4, 1'b0, FILL_MASK, 64'h0C03, 5'd0, 1'b0, NO_SEGMENT},
        '{1'b1, 11'd4, 11'd4, 1'b1, FILL_MASK, 64'h2288, 5'd0, 1'b0, NO_SEGMENT},
        '{1'b1, 11'd5, 11'd2, 1'b1, FILL_MASK, 64'h0145, 5'd0, 1'b0, NO_SEGMENT},
        '{1'b1, 11'd3, 11'd3, 1'b0, FILL_MASK, 64'h0010, 5'd0, 1'b0, NO_SEGMENT},
        '{1'b1, 11'd3, 11'd3, 1'b1, FILL_MASK, 64'h0010, 5'd0, 1'b0, NO_SEGMENT},
        '{1'b1, 11'd6, 11'd6, 1'b1, FILL_ONE, 64'h0, 5'd0, 1'b1,
          '{1'b1, 10'd0, 10'd0, 10'd5, 10'd0}},
        '{1'b1, 11'd3, 11'd5, 1'b0, FILL_ONE, 64'h0, 5'd0, 1'b1,
          '{1'b1, 10'd0, 10'd0, 10'd0, 10'd4}},
        '{1'b1, 11'd8, 11'd8, 1'b0, FILL_MASK, 64'hF0E1_3C78_0FF0_5AA5, 5'd0,
          1'b0, NO_SEGMENT},
        '{1'b1, 11'd8, 11'd8, 1'b1, FILL_MASK, 64'hF0E1_3C78_0FF0_5AA5, 5'd0,
          1'b0, NO_SEGMENT},
        '{1'b1, 11'd4, 11'd8, 1'b0, FILL_MASK, 64'h7E7E_7E7E_7E7E_7E7E, 5'd12,
          1'b0, NO_SEGMENT}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 pixel_valid;
    logic                 pixel_ready;
    logic                 pixel;
    logic                 result_valid;
    logic                 result_ready;
    logic                 found;
    logic [COORD_W-1:0]   start_row;
    logic [COORD_W-1:0]   start_col;
    logic [COORD_W-1:0]   end_row;
    logic [COORD_W-1:0]   end_col;

    longest_line_segment_finder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .start_row    (start_row),
        .start_col    (start_col),
        .end_row      (end_row),
        .end_col      (end_col)
    );

    seg_result_t expected_segments [$];
    int  errors       = 0;
    int  pixels_sent  = 0;
    int  frames_ended = 0;
    int  results_seen = 0;
    int  found_seen   = 0;
    int  hold_token   = 0;
    bit  idle_on      = 1'b1;

    // Predicted state of the block.
    logic [CFG_W-1:0]   size_rows_q;
    logic [CFG_W-1:0]   size_cols_q;
    logic               vert_q;
    logic [COORD_W-1:0] pos_row;
    logic [COORD_W-1:0] pos_col;
    logic [LEN_W-1:0]   hrun_len;
    logic [LEN_W-1:0]   vrun_len [MAX_DIM];
    logic [LEN_W-1:0]   top_len;
    logic [COORD_W-1:0] top_sr;
    logic [COORD_W-1:0] top_sc;
    logic [COORD_W-1:0] top_er;
    logic [COORD_W-1:0] top_ec;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic logic [LEN_W-1:0] bump_run(input logic [LEN_W-1:0] v);
        return (v >= MAX_LEN) ? MAX_LEN : v + LEN_W'(1);
    endfunction

    function automatic int unsigned run_start(input int unsigned last,
                                              input int unsigned len);
        return (len > last + 1) ? 0 : last + 1 - len;
    endfunction

    function automatic void record_segment(input int unsigned len,
                                           input int unsigned sr, input int unsigned sc,
                                           input int unsigned er, input int unsigned ec);
        top_len = LEN_W'(len);
        top_sr  = COORD_W'(sr);
        top_sc  = COORD_W'(sc);
        top_er  = COORD_W'(er);
        top_ec  = COORD_W'(ec);
    endfunction

    function automatic void offer_row_run(input int unsigned len, input int unsigned row,
                                          input int unsigned col);
        if (len > top_len)
            record_segment(len, row, run_start(col, len), row, col);
    endfunction

    // A vertical tie goes to the smaller column; within a column the earlier run stays.
    function automatic void offer_col_run(input int unsigned len, input int unsigned row,
                                          input int unsigned col);
        if (len > top_len || (len == top_len && col < top_sc))
            record_segment(len, run_start(row, len), col, row, col);
    endfunction

    function automatic void clear_trackers();
        pos_row  = '0;
        pos_col  = '0;
        hrun_len = '0;
        foreach (vrun_len[i])
            vrun_len[i] = '0;
        record_segment(0, 0, 0, 0, 0);
    endfunction

    // Applies one pixel; returns 1 when it closes the frame, with its segment.
    function automatic bit advance_pixel(input bit px, output seg_result_t res);
        int unsigned n_rows;
        int unsigned n_cols;
        bit          at_last_col;
        bit          at_last_row;
        n_rows      = clamp_dim(size_rows_q);
        n_cols      = clamp_dim(size_cols_q);
        at_last_col = (pos_col + 32'd1 >= n_cols);
        at_last_row = (pos_row + 32'd1 >= n_rows);
        res         = NO_SEGMENT;
        if (px)
        begin
            hrun_len          = bump_run(hrun_len);
            vrun_len[pos_col] = bump_run(vrun_len[pos_col]);
            if (!vert_q && at_last_col)
                offer_row_run(32'(hrun_len), 32'(pos_row), 32'(pos_col));
            if (vert_q && at_last_row)
                offer_col_run(32'(vrun_len[pos_col]), 32'(pos_row), 32'(pos_col));
        end
        else
        begin
            if (!vert_q && hrun_len != 0 && pos_col != 0)
                offer_row_run(32'(hrun_len), 32'(pos_row), 32'(pos_col) - 1);
            if (vert_q && vrun_len[pos_col] != 0 && pos_row != 0)
                offer_col_run(32'(vrun_len[pos_col]), 32'(pos_row) - 1, 32'(pos_col));
            vrun_len[pos_col] = '0;
            hrun_len          = '0;
        end
        if (!at_last_col)
        begin
            pos_col = pos_col + 1'b1;
            return 1'b0;
        end
        pos_col  = '0;
        hrun_len = '0;
        if (!at_last_row)
        begin
            pos_row = pos_row + 1'b1;
            return 1'b0;
        end
        if (top_len >= 2)
            res = '{1'b1, top_sr, top_sc, top_er, top_ec};
        clear_trackers();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                        input logic [COORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_IMAGE_ROWS:      size_rows_q = data;
            REG_IMAGE_COLS:      size_cols_q = data;
            REG_SEARCH_VERTICAL: vert_q      = data[0];
            default:             ;
        endcase
    endtask

    task automatic write_setup(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                               input logic [CFG_W-1:0] vert_word);
        write_reg(REG_IMAGE_ROWS, rows);
        write_reg(REG_IMAGE_COLS, cols);
        write_reg(REG_SEARCH_VERTICAL, vert_word);
        cfg_we <= 1'b0;
    endtask

    // Offers one pixel, waits for it to be taken and then idles at random.
    task automatic send_pixel(input bit px, input bit use_typed, input seg_result_t typed,
                              output bit done);
        seg_result_t predicted;
        pixel_valid <= 1'b1;
        pixel       <= px;
        do
            @(posedge clk);
        while (!pixel_ready);
        done = advance_pixel(px, predicted);
        pixels_sent++;
        if (done)
        begin
            expected_segments.push_back(use_typed ? typed : predicted);
            frames_ended++;
        end
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering pixels until every pending result is in and the block has settled.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("testbench failed");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold each time it is requested.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        seg_result_t got;
        seg_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got = '{found, start_row, start_col, end_row, end_col};
            if (expected_segments.size() == 0)
            begin
                $display("%0t: result with no frame pending, expected none, got %p",
                         $time, got);
                errors++;
            end
            else
            begin
                want = expected_segments.pop_front();
                check_field("found", COORD_W'(want.found), COORD_W'(got.found));
                check_field("start_row", want.start_row, got.start_row);
                check_field("start_col", want.start_col, got.start_col);
                check_field("end_row", want.end_row, got.end_row);
                check_field("end_col", want.end_col, got.end_col);
                results_seen++;
                if (got.found === 1'b1)
                    found_seen++;
            end
        end
    end

    initial
    begin
        frame_case_t fc;
        int          n;
        int          phase;
        int          frames;
        int          density;
        int          count;
        int          directed_pixels;
        bit          done;
        bit          px;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        pixel_valid = 1'b0;
        pixel       = 1'b0;
        size_rows_q = 11'd1;
        size_cols_q = 11'd1;
        vert_q      = 1'b0;
        clear_trackers();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames. The first one runs on the sizes left by reset.
        for (int k = 0; k < NUM_CASES; k++)
        begin
            fc = FRAME_CASES[k];
            wait_idle();
            if (fc.set_cfg)
                write_setup(fc.rows, fc.cols, {10'b0, fc.vert});
            n = 0;
            do
            begin
                if (fc.mid_at != 0 && n == fc.mid_at)
                begin
                    wait_idle();
                    write_setup(MID_ROWS, MID_COLS, {10'b0, MID_VERT});
                end
                case (fc.fill)
                    FILL_ZERO: px = 1'b0;
                    FILL_ONE:  px = 1'b1;
                    default:   px = fc.mask[n % 64];
                endcase
                send_pixel(px, fc.typed, fc.want, done);
                n++;
            end while (!done);
        end
        directed_pixels = pixels_sent;

        // Random phases. Phase 1 runs without idle cycles, phase 3 stalls the receiver.
        phase = 0;
        while (phase <= 3 || pixels_sent - directed_pixels < RANDOM_PIXELS)
        begin
            wait_idle();
            idle_on = (phase != 1);
            frames  = $urandom_range(1, 6);
            if (phase == 3)
            begin
                write_setup(11'd1, 11'd2, 11'd0);
                hold_token <= hold_token + 1;
                frames = 30;
            end
            else
            begin
                if ($urandom_range(7) == 0)
                    write_reg(REG_UNUSED, CFG_W'($urandom));
                case ((phase == 1) ? 19 : $urandom_range(19))
                    0:
                    begin
                        rows = '0;
                        cols = CFG_W'($urandom_range(0, 6));
                    end
                    1:
                    begin
                        rows = CFG_W'($urandom_range(20, 60));
                        cols = CFG_W'($urandom_range(1, 3));
                    end
                    2:
                    begin
                        rows = CFG_W'($urandom_range(1, 3));
                        cols = CFG_W'($urandom_range(20, 60));
                    end
                    default:
                    begin
                        rows = CFG_W'($urandom_range(1, 6));
                        cols = CFG_W'($urandom_range(1, 6));
                    end
                endcase
                if (phase == 1)
                    frames = 20;
                // Upper bits of the direction word are don't-care.
                write_setup(rows, cols, {10'($urandom), 1'($urandom)});
            end
            for (int f = 0; f < frames; f++)
            begin
                density = $urandom_range(0, 100);
                do
                    send_pixel($urandom_range(99) < density, 1'b0, NO_SEGMENT, done);
                while (!done);
            end
            // Sometimes leave a frame open so the next setup lands mid-frame.
            if (phase != 3 && $urandom_range(4) == 0)
            begin
                count = $urandom_range(1, clamp_dim(size_rows_q) * clamp_dim(size_cols_q));
                repeat (count)
                    send_pixel(1'($urandom_range(1)), 1'b0, NO_SEGMENT, done);
            end
            phase++;
        end
        idle_on = 1'b1;
        wait_idle();

        $display("Summary: %0d pixels over %0d frames, %0d results checked, %0d with a segment.",
                 pixels_sent, frames_ended, results_seen, found_seen);
        $display("Both directions, sizes 1 to 1024 and a %0d-cycle receiver stall were run.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
